/* hdl/mission_download_requester_assert.svh */
// Assertion macros for the mission download requester
`ifndef MISSION_DOWNLOAD_REQUESTER_ASSERT_SVH
`define MISSION_DOWNLOAD_REQUESTER_ASSERT_SVH

`ifndef SYNTH

`define MDR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("mission download requester: assertion failed");

`define MDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mission download requester: assertion failed");

`else

`define MDR_ASSERT(lbl, clk, rstn, prop)

`define MDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hdl/mdr_pkg.sv */
// Types and constants of the mission download requester
`default_nettype none

package mdr_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_ITEM  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_CANCEL = 3'd1,
        CMD_COUNT  = 3'd2,
        CMD_ITEM   = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_t;

    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_LIST = 2'd1;
    localparam logic [1:0] SEND_ITEM = 2'd2;
    localparam logic [1:0] SEND_ACK  = 2'd3;

    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_STARTED = 2'd1;
    localparam logic [1:0] OUT_OK      = 2'd2;
    localparam logic [1:0] OUT_FAILED  = 2'd3;

    localparam logic [2:0] FAIL_NONE     = 3'd0;
    localparam logic [2:0] FAIL_NEG_CNT  = 3'd1;
    localparam logic [2:0] FAIL_FUTURE   = 3'd2;
    localparam logic [2:0] FAIL_TIMEOUT  = 3'd3;
    localparam logic [2:0] FAIL_CANCEL   = 3'd4;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_RETRIES = 1'b1;

    localparam logic [15:0] TIMEOUT_RST = 16'd1000;
    localparam logic [3:0]  RETRIES_RST = 4'd3;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] send_seq;
        logic [1:0]  outcome;
        logic [2:0]  fail_code;
        logic        progress_valid;
        logic [15:0] done_count;
        logic [15:0] total_count;
        logic        busy_res;
        logic        item_valid;
        logic [15:0] item_index;
        logic [63:0] item_out_data;
    } res_t;

endpackage

`default_nettype wire

/* hdl/mdr_cmd_if.sv */
// Command channel interface of the mission download requester
`default_nettype none

interface mdr_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [16:0] count;
    logic [15:0]        item_seq;
    logic [63:0]        item_data;

    modport source (output valid, command, count, item_seq, item_data, input ready);
    modport sink (input valid, command, count, item_seq, item_data, output ready);
endinterface

`default_nettype wire

/* hdl/mdr_res_if.sv */
// Result channel interface of the mission download requester
`default_nettype none

interface mdr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  send_kind;
    logic [15:0] send_seq;
    logic [1:0]  outcome;
    logic [2:0]  fail_code;
    logic        progress_valid;
    logic [15:0] done_count;
    logic [15:0] total_count;
    logic        busy_res;
    logic        item_valid;
    logic [15:0] item_index;
    logic [63:0] item_out_data;

    modport source (
        output valid, send_kind, send_seq, outcome, fail_code, progress_valid,
               done_count, total_count, busy_res, item_valid, item_index, item_out_data,
        input  ready
    );
    modport sink (
        input  valid, send_kind, send_seq, outcome, fail_code, progress_valid,
               done_count, total_count, busy_res, item_valid, item_index, item_out_data,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/mission_download_requester.sv */
// Top level of the mission download requester
//
//   channel  | direction | handshake           | payload
//   cmd      | in        | valid / ready       | command, count, item_seq, item_data
//   res      | out       | valid / ready       | send_kind ... item_out_data
//   apb      | in        | psel/penable/pready | timeout_ticks, max_retries
//
// One command transaction per cycle while the skid entry is empty; each result is registered in the output buffer.
// State and result are computed in one pass from the protocol registers.
// A two-entry output buffer takes one more transaction while res stalls.
// Reset idles the protocol, empties the buffer and loads the register defaults.
`default_nettype none
`include "mission_download_requester_assert.svh"

module mission_download_requester #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    mdr_cmd_if.sink          cmd,
    mdr_res_if.source        res
);
    import mdr_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam logic [15:0] CMAX16 = 16'((1 << COUNT_BITS) - 1);

    logic [15:0]   timeout_reg;
    logic [3:0]    retries_reg;

    phase_t        phase_reg, phase_next;
    logic [CB-1:0] expected_total_reg, expected_total_next;
    logic [CB-1:0] next_seq_reg, next_seq_next;
    logic [3:0]    retry_reg, retry_next;
    logic          last_list_reg, last_list_next;
    logic          timer_running_reg, timer_running_next;
    logic [15:0]   timer_left_reg, timer_left_next;

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    res_t          out_reg, out_next;
    res_t          skid_reg, skid_next;
    res_t          res_new;

    logic          accept;
    logic          pop;
    logic          cfg_write;
    logic          busy;
    logic          cnt_neg;
    logic [15:0]   cnt_mag;
    logic [15:0]   cnt_sat;
    logic [CB-1:0] cnt_val;
    logic          cnt_zero;
    logic [15:0]   seq_cur16;
    logic          seq_future;
    logic          seq_match;
    logic [CB-1:0] seq_inc;
    logic          last_item;
    logic [15:0]   timer_dec;
    logic          expire;
    logic          retry_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_TIMEOUT)
        begin
            prdata = 32'(timeout_reg);
        end
        else
        begin
            prdata = 32'(retries_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            retries_reg <= RETRIES_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_TIMEOUT && pwdata[15:0] != 16'd0)
            begin
                timeout_reg <= pwdata[15:0];
            end
            if (paddr[2] == REG_RETRIES && pwdata[3:0] != 4'd0)
            begin
                retries_reg <= pwdata[3:0];
            end
        end
    end

    assign accept     = cmd.valid && cmd.ready;
    assign cmd.ready  = !skid_valid_reg;
    assign pop        = out_valid_reg && res.ready;

    assign busy       = (phase_reg == PH_COUNT) || (phase_reg == PH_ITEM);
    assign cnt_neg    = cmd.count[16];
    assign cnt_mag    = cmd.count[15:0];
    assign cnt_sat    = (cnt_mag > CMAX16) ? CMAX16 : cnt_mag;
    assign cnt_val    = cnt_sat[CB-1:0];
    assign cnt_zero   = (cnt_val == '0);
    assign seq_cur16  = 16'(next_seq_reg);
    assign seq_future = cmd.item_seq > seq_cur16;
    assign seq_match  = cmd.item_seq == seq_cur16;
    assign seq_inc    = next_seq_reg + 1'b1;
    assign last_item  = seq_inc >= expected_total_reg;
    assign timer_dec  = (timer_left_reg != 16'd0) ? (timer_left_reg - 16'd1) : 16'd0;
    assign expire     = timer_running_reg && (timer_dec == 16'd0);
    assign retry_out  = retry_reg >= retries_reg;

    // protocol next state
    always_comb
    begin
        phase_next          = phase_reg;
        expected_total_next = expected_total_reg;
        next_seq_next       = next_seq_reg;
        retry_next          = retry_reg;
        last_list_next      = last_list_reg;
        timer_running_next  = timer_running_reg;
        timer_left_next     = timer_left_reg;
        if (accept)
        begin
            case (cmd_t'(cmd.command))
                CMD_START:
                begin
                    if (!busy)
                    begin
                        expected_total_next = '0;
                        next_seq_next       = '0;
                        retry_next          = 4'd0;
                        last_list_next      = 1'b1;
                        phase_next          = PH_COUNT;
                        timer_running_next  = 1'b1;
                        timer_left_next     = timeout_reg;
                    end
                end
                CMD_CANCEL:
                begin
                    if (busy)
                    begin
                        phase_next         = PH_IDLE;
                        timer_running_next = 1'b0;
                        timer_left_next    = 16'd0;
                    end
                end
                CMD_COUNT:
                begin
                    if (phase_reg == PH_COUNT)
                    begin
                        if (cnt_neg || cnt_zero)
                        begin
                            phase_next         = PH_IDLE;
                            timer_running_next = 1'b0;
                            timer_left_next    = 16'd0;
                        end
                        else
                        begin
                            next_seq_next      = '0;
                            retry_next         = 4'd0;
                            phase_next         = PH_ITEM;
                            last_list_next     = 1'b0;
                            timer_running_next = 1'b1;
                            timer_left_next    = timeout_reg;
                        end
                        if (!cnt_neg)
                        begin
                            expected_total_next = cnt_val;
                        end
                    end
                end
                CMD_ITEM:
                begin
                    if (phase_reg == PH_ITEM)
                    begin
                        if (seq_future)
                        begin
                            phase_next         = PH_IDLE;
                            timer_running_next = 1'b0;
                            timer_left_next    = 16'd0;
                        end
                        else if (seq_match)
                        begin
                            next_seq_next = seq_inc;
                            retry_next    = 4'd0;
                            if (last_item)
                            begin
                                phase_next         = PH_IDLE;
                                timer_running_next = 1'b0;
                                timer_left_next    = 16'd0;
                            end
                            else
                            begin
                                last_list_next     = 1'b0;
                                timer_running_next = 1'b1;
                                timer_left_next    = timeout_reg;
                            end
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (timer_running_reg)
                    begin
                        timer_left_next = timer_dec;
                        if (expire)
                        begin
                            timer_running_next = 1'b0;
                            if (busy)
                            begin
                                if (retry_out)
                                begin
                                    phase_next      = PH_IDLE;
                                    timer_left_next = 16'd0;
                                end
                                else
                                begin
                                    retry_next         = retry_reg + 4'd1;
                                    timer_running_next = 1'b1;
                                    timer_left_next    = timeout_reg;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result of the current transaction
    always_comb
    begin
        res_new = '0;
        case (cmd_t'(cmd.command))
            CMD_START:
            begin
                if (!busy)
                begin
                    res_new.send_kind = SEND_LIST;
                    res_new.outcome   = OUT_STARTED;
                end
            end
            CMD_CANCEL:
            begin
                if (busy)
                begin
                    res_new.outcome   = OUT_FAILED;
                    res_new.fail_code = FAIL_CANCEL;
                end
            end
            CMD_COUNT:
            begin
                if (phase_reg == PH_COUNT)
                begin
                    if (cnt_neg)
                    begin
                        res_new.outcome   = OUT_FAILED;
                        res_new.fail_code = FAIL_NEG_CNT;
                    end
                    else
                    begin
                        res_new.progress_valid = 1'b1;
                        res_new.total_count    = 16'(cnt_val);
                        if (cnt_zero)
                        begin
                            res_new.send_kind = SEND_ACK;
                            res_new.outcome   = OUT_OK;
                        end
                        else
                        begin
                            res_new.send_kind = SEND_ITEM;
                        end
                    end
                end
            end
            CMD_ITEM:
            begin
                if (phase_reg == PH_ITEM)
                begin
                    if (seq_future)
                    begin
                        res_new.outcome   = OUT_FAILED;
                        res_new.fail_code = FAIL_FUTURE;
                    end
                    else if (seq_match)
                    begin
                        res_new.item_valid     = 1'b1;
                        res_new.item_index     = seq_cur16;
                        res_new.item_out_data  = cmd.item_data;
                        res_new.progress_valid = 1'b1;
                        res_new.done_count     = 16'(seq_inc);
                        res_new.total_count    = 16'(expected_total_reg);
                        if (last_item)
                        begin
                            res_new.send_kind = SEND_ACK;
                            res_new.outcome   = OUT_OK;
                        end
                        else
                        begin
                            res_new.send_kind = SEND_ITEM;
                            res_new.send_seq  = 16'(seq_inc);
                        end
                    end
                end
            end
            CMD_TICK:
            begin
                if (expire && busy)
                begin
                    if (retry_out)
                    begin
                        res_new.outcome   = OUT_FAILED;
                        res_new.fail_code = FAIL_TIMEOUT;
                    end
                    else if (last_list_reg)
                    begin
                        res_new.send_kind = SEND_LIST;
                    end
                    else
                    begin
                        res_new.send_kind = SEND_ITEM;
                        res_new.send_seq  = seq_cur16;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res_new.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            expected_total_reg <= '0;
            next_seq_reg       <= '0;
            retry_reg          <= 4'd0;
            last_list_reg      <= 1'b1;
            timer_running_reg  <= 1'b0;
            timer_left_reg     <= 16'd0;
        end
        else
        begin
            phase_reg          <= phase_next;
            expected_total_reg <= expected_total_next;
            next_seq_reg       <= next_seq_next;
            retry_reg          <= retry_next;
            last_list_reg      <= last_list_next;
            timer_running_reg  <= timer_running_next;
            timer_left_reg     <= timer_left_next;
        end
    end

    // output buffer: result register plus skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = res_new;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res_new;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.send_kind      = out_reg.send_kind;
    assign res.send_seq       = out_reg.send_seq;
    assign res.outcome        = out_reg.outcome;
    assign res.fail_code      = out_reg.fail_code;
    assign res.progress_valid = out_reg.progress_valid;
    assign res.done_count     = out_reg.done_count;
    assign res.total_count    = out_reg.total_count;
    assign res.busy_res       = out_reg.busy_res;
    assign res.item_valid     = out_reg.item_valid;
    assign res.item_index     = out_reg.item_index;
    assign res.item_out_data  = out_reg.item_out_data;

    `MDR_ASSERT(a_skid_behind_out, clk, rst_n, !skid_valid_reg || out_valid_reg)
    `MDR_ASSERT(a_timer_only_busy, clk, rst_n, !timer_running_reg || phase_reg != PH_IDLE)
    `MDR_ASSERT(a_seq_below_total, clk, rst_n, phase_reg != PH_ITEM || next_seq_reg < expected_total_reg)
    `MDR_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_reg && pop, out_valid_reg && !skid_valid_reg)

endmodule

`default_nettype wire

/* tb/mdr_download_checker.sv */
`timescale 1ns / 1ps
// Scoreboard of the mission download requester: predicts and checks every result transaction
module mdr_download_checker
    import mdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    mdr_cmd_if          cmd,
    mdr_res_if          res,
    output int          mismatches,
    output int          outstanding
);

    localparam int REPORT_LIMIT = 10;

    logic [15:0] tmo_cfg;
    logic [3:0]  retry_limit;

    phase_t      dl_phase;
    logic [15:0] total_exp;
    logic [16:0] seq_next;
    logic [3:0]  retries_used;
    logic        list_last;
    logic        tmr_on;
    logic [15:0] tmr_left;

    res_t        next_res;
    res_t        got_res;
    res_t        want_res;
    res_t        owed_results[$];
    int          bad_count;

    function automatic string fmt_res(res_t r);
        return $sformatf({"kind=%0d seq=%0d out=%0d code=%0d pv=%0d done=%0d tot=%0d ",
                          "busy=%0d iv=%0d idx=%0d data=%h"},
                         r.send_kind, r.send_seq, r.outcome, r.fail_code, r.progress_valid,
                         r.done_count, r.total_count, r.busy_res, r.item_valid,
                         r.item_index, r.item_out_data);
    endfunction

    function automatic logic requester_busy();
        return dl_phase == PH_COUNT || dl_phase == PH_ITEM;
    endfunction

    task automatic abort_download(input logic [2:0] code);
        tmr_on = 1'b0;
        tmr_left = '0;
        dl_phase = PH_IDLE;
        next_res.outcome = OUT_FAILED;
        next_res.fail_code = code;
    endtask

    task automatic close_download();
        tmr_on = 1'b0;
        tmr_left = '0;
        dl_phase = PH_IDLE;
        next_res.send_kind = SEND_ACK;
        next_res.outcome = OUT_OK;
    endtask

    task automatic ask_item();
        next_res.send_kind = SEND_ITEM;
        next_res.send_seq = seq_next[15:0];
        list_last = 1'b0;
    endtask

    task automatic rearm();
        tmr_on = 1'b1;
        tmr_left = tmo_cfg;
    endtask

    task automatic advance_requester(input logic [2:0] c, input logic [16:0] cnt,
                                     input logic [15:0] sq, input logic [63:0] d);
        next_res = '0;
        case (c)
            CMD_START:
            begin
                if (!requester_busy())
                begin
                    total_exp = '0;
                    seq_next = '0;
                    retries_used = '0;
                    list_last = 1'b1;
                    dl_phase = PH_COUNT;
                    next_res.outcome = OUT_STARTED;
                    next_res.send_kind = SEND_LIST;
                    rearm();
                end
            end
            CMD_CANCEL:
            begin
                if (requester_busy())
                    abort_download(FAIL_CANCEL);
            end
            CMD_COUNT:
            begin
                if (dl_phase == PH_COUNT)
                begin
                    if (cnt[16])
                        abort_download(FAIL_NEG_CNT);
                    else
                    begin
                        tmr_on = 1'b0;
                        total_exp = cnt[15:0];
                        next_res.progress_valid = 1'b1;
                        next_res.total_count = cnt[15:0];
                        if (cnt[15:0] == '0)
                            close_download();
                        else
                        begin
                            seq_next = '0;
                            retries_used = '0;
                            dl_phase = PH_ITEM;
                            ask_item();
                            rearm();
                        end
                    end
                end
            end
            CMD_ITEM:
            begin
                if (dl_phase == PH_ITEM)
                begin
                    if ({1'b0, sq} > seq_next)
                        abort_download(FAIL_FUTURE);
                    else if ({1'b0, sq} == seq_next)
                    begin
                        tmr_on = 1'b0;
                        next_res.item_valid = 1'b1;
                        next_res.item_index = seq_next[15:0];
                        next_res.item_out_data = d;
                        seq_next = seq_next + 17'd1;
                        retries_used = '0;
                        next_res.progress_valid = 1'b1;
                        next_res.done_count = seq_next[15:0];
                        next_res.total_count = total_exp;
                        if (seq_next >= {1'b0, total_exp})
                            close_download();
                        else
                        begin
                            ask_item();
                            rearm();
                        end
                    end
                end
            end
            CMD_TICK:
            begin
                if (tmr_on)
                begin
                    if (tmr_left != '0)
                        tmr_left = tmr_left - 16'd1;
                    if (tmr_left == '0)
                    begin
                        tmr_on = 1'b0;
                        if (requester_busy())
                        begin
                            if (retries_used >= retry_limit)
                                abort_download(FAIL_TIMEOUT);
                            else
                            begin
                                retries_used = retries_used + 4'd1;
                                if (list_last)
                                    next_res.send_kind = SEND_LIST;
                                else
                                    ask_item();
                                rearm();
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        next_res.busy_res = requester_busy();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_cfg = TIMEOUT_RST;
            retry_limit = RETRIES_RST;
            dl_phase = PH_IDLE;
            total_exp = '0;
            seq_next = '0;
            retries_used = '0;
            list_last = 1'b1;
            tmr_on = 1'b0;
            tmr_left = '0;
            owed_results.delete();
            bad_count = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_TIMEOUT:
                    begin
                        if (pwdata[15:0] != '0)
                            tmo_cfg = pwdata[15:0];
                    end
                    REG_RETRIES:
                    begin
                        if (pwdata[3:0] != '0)
                            retry_limit = pwdata[3:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (res.valid && res.ready)
            begin
                got_res = {res.send_kind, res.send_seq, res.outcome, res.fail_code,
                           res.progress_valid, res.done_count, res.total_count,
                           res.busy_res, res.item_valid, res.item_index, res.item_out_data};
                if (owed_results.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= REPORT_LIMIT)
                        $display("unexpected result transaction: %s", fmt_res(got_res));
                end
                else
                begin
                    want_res = owed_results.pop_front();
                    if (got_res !== want_res)
                    begin
                        bad_count++;
                        if (bad_count <= REPORT_LIMIT)
                            $display("result mismatch:\n  expected %s\n  actual   %s",
                                     fmt_res(want_res), fmt_res(got_res));
                    end
                end
            end

            if (cmd.valid && cmd.ready)
            begin
                advance_requester(cmd.command, cmd.count, cmd.item_seq, cmd.item_data);
                owed_results.push_back(next_res);
            end

            mismatches <= bad_count;
            outstanding <= owed_results.size();
        end
    end

endmodule

/* tb/tb_mission_download_requester.sv */
`timescale 1ns / 1ps
// Testbench top of the mission download requester: clock, reset, stimulus and verdict
module tb_mission_download_requester;
    import mdr_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         ITEM_BUDGET  = 1650;
    localparam int         PHASE_COUNT  = 8;
    localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
    localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mdr_cmd_if cmd_ch();
    mdr_res_if res_ch();

    int mismatches;
    int outstanding;
    int cycles = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cur_tmo = TIMEOUT_RST;

    int tmo_set[4]   = '{1, 65535, 3, 7};
    int retry_set[4] = '{1, 15, 2, 4};

    mission_download_requester dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .res     (res_ch)
    );

    mdr_download_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_mission_download_requester failed");
            $finish;
        end
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [16:0] rand17();
        return 17'($urandom);
    endfunction

    task automatic push_cmd(input logic [2:0] c, input logic [16:0] cnt,
                            input logic [15:0] sq, input logic [63:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.count <= cnt;
        cmd_ch.item_seq <= sq;
        cmd_ch.item_data <= d;
        do @(posedge clk); while (!cmd_ch.ready);
        items_sent++;
    endtask

    task automatic push_rand(input logic [2:0] c);
        push_cmd(c, rand17(), 16'($urandom), rand64());
    endtask

    // hold off until every owed result transaction is back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic tick_burst();
        int n;
        if ($urandom_range(99) < 35)
        begin
            n = (cur_tmo > 12) ? $urandom_range(1, 6) : $urandom_range(1, cur_tmo * 3 + 2);
            repeat (n) push_rand(CMD_TICK);
        end
    endtask

    task automatic run_download();
        int          pick;
        int          total;
        int          idx;
        logic [16:0] cnt;
        logic        big_count;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            repeat ($urandom_range(1, 4))
                push_rand(3'($urandom_range(CMD_START, CMD_UNDEF_HI)));
            return;
        end
        push_rand(CMD_START);
        tick_burst();
        if ($urandom_range(99) < 5)
            push_rand(CMD_START);
        pick = $urandom_range(99);
        big_count = 1'b0;
        if (pick < 10)
            cnt = '0;
        else if (pick < 18)
            cnt = {1'b1, 16'($urandom)};
        else if (pick < 23)
        begin
            cnt = 17'($urandom_range(7, 65535));
            big_count = 1'b1;
        end
        else
            cnt = 17'($urandom_range(1, 6));
        push_cmd(CMD_COUNT, cnt, 16'($urandom), rand64());
        if (cnt[16] || cnt == '0)
            return;
        total = big_count ? $urandom_range(1, 4) : int'(cnt);
        idx = 0;
        while (idx < total)
        begin
            tick_burst();
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                push_rand(CMD_CANCEL);
                return;
            end
            else if (pick < 7)
            begin
                push_cmd(CMD_ITEM, rand17(), 16'($urandom_range(idx + 1, 65535)), rand64());
                return;
            end
            else if (pick < 15 && idx > 0)
                push_cmd(CMD_ITEM, rand17(), 16'($urandom_range(0, idx - 1)), rand64());
            else
            begin
                push_cmd(CMD_ITEM, rand17(), 16'(idx), rand64());
                idx++;
            end
        end
        if (big_count)
            push_rand(CMD_CANCEL);
    endtask

    initial
    begin
        int goal;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= CMD_TICK;
        cmd_ch.count <= '0;
        cmd_ch.item_seq <= '0;
        cmd_ch.item_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle-state commands, stray replies and undefined codes
        push_cmd(CMD_TICK, '0, '0, '0);
        push_cmd(CMD_CANCEL, '0, '0, '0);
        push_cmd(CMD_COUNT, 17'd5, '0, '0);
        push_cmd(CMD_ITEM, '0, '0, '1);
        push_cmd(CMD_UNDEF_LO, '1, '1, '1);
        push_cmd(CMD_UNDEF_HI, '0, '0, '0);
        // full download with a busy start, early item, stale item
        push_cmd(CMD_START, '0, '0, '0);
        push_cmd(CMD_START, '1, '1, '1);
        push_cmd(CMD_ITEM, '0, '0, '1);
        push_cmd(CMD_COUNT, 17'd2, '0, '0);
        push_cmd(CMD_TICK, '0, '0, '0);
        push_cmd(CMD_ITEM, '0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_cmd(CMD_ITEM, '0, 16'd0, 64'h0123_4567_89AB_CDEF);
        push_cmd(CMD_ITEM, '1, 16'd1, '0);
        // negative counts
        push_cmd(CMD_START, '0, '0, '0);
        push_cmd(CMD_COUNT, 17'h18000, '0, '0);
        push_cmd(CMD_START, '0, '0, '0);
        push_cmd(CMD_COUNT, 17'h1FFFF, '0, '0);
        // empty mission
        push_cmd(CMD_START, '0, '0, '0);
        push_cmd(CMD_COUNT, 17'd0, '0, '0);
        // largest count, then a future item
        push_cmd(CMD_START, '0, '0, '0);
        push_cmd(CMD_COUNT, 17'd65535, '0, '0);
        push_cmd(CMD_ITEM, '0, 16'hFFFF, '1);
        // cancel while busy
        push_cmd(CMD_START, '0, '0, '0);
        push_cmd(CMD_COUNT, 17'd1, '0, '0);
        push_cmd(CMD_CANCEL, '0, '0, '0);
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            cur_tmo = tmo_set[ph / 2];
            write_reg(REG_TIMEOUT, {16'($urandom), 16'(cur_tmo)});
            write_reg(REG_RETRIES, {28'($urandom), 4'(retry_set[ph / 2])});
            if (ph == 2)
            begin
                // zero writes must leave the registers alone
                write_reg(REG_TIMEOUT, {16'($urandom), 16'h0000});
                write_reg(REG_RETRIES, {28'($urandom), 4'h0});
            end
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 67;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct = 35;
                    stall_pct = 35;
                end
            endcase
            goal = items_sent + ITEM_BUDGET / PHASE_COUNT;
            while (items_sent < goal)
            begin
                if ($urandom_range(99) < 3)
                    drain();
                run_download();
            end
            drain();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_mission_download_requester passed");
        else
            $display("tb_mission_download_requester failed");
        $finish;
    end

endmodule
